@@ hw/rtl/kscg_pkg.sv @@
package kscg_pkg;

    typedef enum logic [1:0] {
        CMD_KEY_DOWN   = 2'd0,
        CMD_KEY_UP     = 2'd1,
        CMD_RESET_LINE = 2'd2,
        CMD_COMMAND    = 2'd3
    } cmd_t;

    localparam int unsigned MAX_BYTES = 4;

    localparam logic [7:0] KEY_CAPS  = 8'h14;
    localparam logic [7:0] KEY_KANA  = 8'h15;
    localparam logic [7:0] SC_CAPS   = 8'h71;
    localparam logic [7:0] SC_KANA   = 8'h72;
    localparam logic [7:0] BREAK_BIT = 8'h80;

    // keyboard reset announcement, sent first byte first
    localparam logic [MAX_BYTES-1:0][7:0] RESET_SEQ = {8'he0, 8'hc0, 8'h81, 8'ha0};

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
    } burst_t;

    typedef struct packed {
        logic       mapped;
        logic [6:0] code;
    } key_map_t;

    // host key code to scan code
    function automatic key_map_t key_rom(input logic [7:0] key);
        logic [7:0] r;
        r = 8'h00;
        case (key)
            8'h08: r = 8'h8e;
            8'h09: r = 8'h8f;
            8'h0d: r = 8'h9c;
            8'h10: r = 8'hf0;
            8'h11: r = 8'hf4;
            8'h12: r = 8'hf3;
            8'h13: r = 8'he0;
            8'h1b: r = 8'h80;
            8'h1c: r = 8'hb5;
            8'h1d: r = 8'hd1;
            8'h20: r = 8'hb4;
            8'h21: r = 8'hb6;
            8'h22: r = 8'hb7;
            8'h23: r = 8'hbf;
            8'h24: r = 8'hbe;
            8'h25: r = 8'hbb;
            8'h26: r = 8'hba;
            8'h27: r = 8'hbc;
            8'h28: r = 8'hbd;
            8'h2d: r = 8'hb8;
            8'h2e: r = 8'hb9;
            8'h30: r = 8'h8a;
            8'h31: r = 8'h81;
            8'h32: r = 8'h82;
            8'h33: r = 8'h83;
            8'h34: r = 8'h84;
            8'h35: r = 8'h85;
            8'h36: r = 8'h86;
            8'h37: r = 8'h87;
            8'h38: r = 8'h88;
            8'h39: r = 8'h89;
            8'h40: r = 8'h8a;
            8'h41: r = 8'h9d;
            8'h42: r = 8'had;
            8'h43: r = 8'hab;
            8'h44: r = 8'h9f;
            8'h45: r = 8'h92;
            8'h46: r = 8'ha0;
            8'h47: r = 8'ha1;
            8'h48: r = 8'ha2;
            8'h49: r = 8'h97;
            8'h4a: r = 8'ha3;
            8'h4b: r = 8'ha4;
            8'h4c: r = 8'ha5;
            8'h4d: r = 8'haf;
            8'h4e: r = 8'hae;
            8'h4f: r = 8'h98;
            8'h50: r = 8'h99;
            8'h51: r = 8'h90;
            8'h52: r = 8'h93;
            8'h53: r = 8'h9e;
            8'h54: r = 8'h94;
            8'h55: r = 8'h96;
            8'h56: r = 8'hac;
            8'h57: r = 8'h91;
            8'h58: r = 8'haa;
            8'h59: r = 8'h95;
            8'h5a: r = 8'ha9;
            8'h60: r = 8'hce;
            8'h61: r = 8'hca;
            8'h62: r = 8'hcb;
            8'h63: r = 8'hcc;
            8'h64: r = 8'hc6;
            8'h65: r = 8'hc7;
            8'h66: r = 8'hc8;
            8'h67: r = 8'hc2;
            8'h68: r = 8'hc3;
            8'h69: r = 8'hc4;
            8'h6a: r = 8'hc5;
            8'h6b: r = 8'hc9;
            8'h6d: r = 8'hc0;
            8'h6e: r = 8'hd0;
            8'h6f: r = 8'hc1;
            8'h70: r = 8'he2;
            8'h71: r = 8'he3;
            8'h72: r = 8'he4;
            8'h73: r = 8'he5;
            8'h74: r = 8'he6;
            8'h75: r = 8'he7;
            8'h76: r = 8'he8;
            8'h77: r = 8'he9;
            8'h78: r = 8'hea;
            8'h79: r = 8'heb;
            8'h7a: r = 8'he0;
            8'h7b: r = 8'he1;
            8'hba: r = 8'ha7;
            8'hbb: r = 8'ha6;
            8'hbc: r = 8'hb0;
            8'hbd: r = 8'h8b;
            8'hbe: r = 8'hb1;
            8'hbf: r = 8'hb2;
            8'hc0: r = 8'h9a;
            8'hdb: r = 8'h9b;
            8'hdc: r = 8'h8d;
            8'hdd: r = 8'ha8;
            8'hde: r = 8'h8c;
            8'he2: r = 8'hb3;
            default: r = 8'h00;
        endcase
        return key_map_t'(r);
    endfunction

endpackage

@@ hw/rtl/kscg_ifs.sv @@
interface kscg_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] value;
    logic [7:0] value_mask;

    modport source (output valid, cmd, value, value_mask, input ready);
    modport sink   (input valid, cmd, value, value_mask, output ready);
endinterface

interface kscg_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;
    logic       last;

    modport source (output valid, scan_byte, last, input ready);
    modport sink   (input valid, scan_byte, last, output ready);
endinterface

@@ hw/rtl/kscg_event.sv @@
module kscg_event
    import kscg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kscg_evt_if.sink    evt,
    output logic        burst_valid,
    output burst_t      burst,
    input  logic        burst_ready
);

    logic       s1_valid_reg;
    logic [1:0] s1_cmd_reg;
    logic [7:0] s1_value_reg;
    logic [7:0] s1_mask_reg;

    logic [127:0] marks_reg;
    logic [127:0] marks_next;
    logic         caps_reg;
    logic         caps_next;
    logic         kana_reg;
    logic         kana_next;
    logic         line_reg;
    logic         line_next;

    key_map_t   km;
    logic       mark;
    logic [7:0] masked;
    logic [7:0] make_byte;
    logic [7:0] break_byte;
    logic       advance;

    always_comb
    begin
        km         = key_rom(s1_value_reg);
        mark       = marks_reg[km.code];
        masked     = s1_value_reg & s1_mask_reg;
        make_byte  = {1'b0, km.code};
        break_byte = make_byte | BREAK_BIT;

        burst      = '0;
        marks_next = marks_reg;
        caps_next  = caps_reg;
        kana_next  = kana_reg;
        line_next  = line_reg;

        unique case (cmd_t'(s1_cmd_reg))
            CMD_KEY_DOWN:
            begin
                if (s1_value_reg == KEY_CAPS)
                begin
                    caps_next      = !caps_reg;
                    burst.bytes[0] = caps_reg ? (SC_CAPS | BREAK_BIT) : SC_CAPS;
                    burst.cnt      = 3'd1;
                end
                else if (s1_value_reg == KEY_KANA)
                begin
                    kana_next      = !kana_reg;
                    burst.bytes[0] = kana_reg ? (SC_KANA | BREAK_BIT) : SC_KANA;
                    burst.cnt      = 3'd1;
                end
                else if (km.mapped)
                begin
                    marks_next[km.code] = 1'b1;
                    if (mark)
                    begin
                        burst.bytes[0] = break_byte;
                        burst.bytes[1] = make_byte;
                        burst.cnt      = 3'd2;
                    end
                    else
                    begin
                        burst.bytes[0] = make_byte;
                        burst.cnt      = 3'd1;
                    end
                end
            end
            CMD_KEY_UP:
            begin
                if (km.mapped)
                begin
                    marks_next[km.code] = 1'b0;
                    if (mark)
                    begin
                        burst.bytes[0] = break_byte;
                        burst.cnt      = 3'd1;
                    end
                end
            end
            CMD_RESET_LINE:
            begin
                line_next = |masked;
                if (line_reg && !(|masked))
                begin
                    burst.bytes = RESET_SEQ;
                    burst.cnt   = 3'(MAX_BYTES);
                end
            end
            CMD_COMMAND:
            begin
                if (masked == 8'h00)
                begin
                    burst.bytes = RESET_SEQ;
                    burst.cnt   = 3'(MAX_BYTES);
                end
            end
        endcase
    end

    // items with nothing to send retire without waiting for the sequencer
    assign advance     = s1_valid_reg && ((burst.cnt == 3'd0) || burst_ready);
    assign burst_valid = s1_valid_reg && (burst.cnt != 3'd0);
    assign evt.ready   = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            marks_reg    <= '0;
            caps_reg     <= 1'b0;
            kana_reg     <= 1'b0;
            line_reg     <= 1'b0;
        end
        else
        begin
            if (evt.ready)
                s1_valid_reg <= evt.valid;
            if (advance)
            begin
                marks_reg <= marks_next;
                caps_reg  <= caps_next;
                kana_reg  <= kana_next;
                line_reg  <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            s1_cmd_reg   <= evt.cmd;
            s1_value_reg <= evt.value;
            s1_mask_reg  <= evt.value_mask;
        end
    end

endmodule

@@ hw/rtl/kscg_serial.sv @@
module kscg_serial
    import kscg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        burst_valid,
    input  burst_t      burst,
    output logic        burst_ready,
    kscg_scan_if.source scan
);

    logic                      busy_reg;
    logic [MAX_BYTES-1:0][7:0] bytes_reg;
    logic [2:0]                cnt_reg;
    logic [1:0]                idx_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic cur_last;
    logic out_free;
    logic move;

    assign cur_last    = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign out_free    = !out_valid_reg || scan.ready;
    assign move        = busy_reg && out_free;
    assign burst_ready = !busy_reg || (move && cur_last);

    assign scan.valid     = out_valid_reg;
    assign scan.scan_byte = out_byte_reg;
    assign scan.last      = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (burst_ready)
            begin
                busy_reg <= burst_valid;
                idx_reg  <= '0;
            end
            else if (move)
                idx_reg <= idx_reg + 2'd1;

            if (out_free)
                out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_ready && burst_valid)
        begin
            bytes_reg <= burst.bytes;
            cnt_reg   <= burst.cnt;
        end
        if (move)
        begin
            out_byte_reg <= bytes_reg[idx_reg];
            out_last_reg <= cur_last;
        end
    end

endmodule

@@ hw/rtl/keyboard_scan_code_generator.sv @@
// channel | dir | payload                      | transaction
// evt     | in  | cmd[1:0] value[7:0] mask[7:0] | host key or control event
// scan    | out | scan_byte[7:0] last          | one scan byte
//
// An event is decoded in the cycle after acceptance; its scan bytes then pass
// through the byte sequencer to the output register, one byte per cycle while
// the output is not stalled. An event sending n bytes (1 to 4) holds the byte
// sequencer for those bytes; events sending nothing retire without it.
// rst_n clears key marks, lock states and the reset line level.
// A stalled output holds its byte while one further event waits decoded.
module keyboard_scan_code_generator
    import kscg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kscg_evt_if.sink    evt,
    kscg_scan_if.source scan
);

    logic   burst_valid;
    logic   burst_ready;
    burst_t burst;

    kscg_event u_event (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .burst_valid (burst_valid),
        .burst       (burst),
        .burst_ready (burst_ready)
    );

    kscg_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst       (burst),
        .burst_ready (burst_ready),
        .scan        (scan)
    );

endmodule

@@ hw/rtl/kscg_checker.sv @@
module kscg_checker
    import kscg_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       scan_valid,
    input logic       scan_ready,
    input logic [7:0] scan_byte,
    input logic       scan_last
);

    // a stalled byte holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid && !scan_ready |=>
            scan_valid && $stable(scan_byte) && $stable(scan_last))
        else $error("scan byte changed while stalled");

    // nothing can reach the output in the first cycle out of reset
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !scan_valid)
        else $error("scan output valid straight after reset");

    // the rest of a multi-byte sequence follows without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid && scan_ready && !scan_last |=> scan_valid)
        else $error("gap inside a scan byte sequence");

    // lock keys send exactly one byte
    a_lock: assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid && (scan_byte == SC_CAPS || scan_byte == (SC_CAPS | BREAK_BIT) ||
                       scan_byte == SC_KANA || scan_byte == (SC_KANA | BREAK_BIT))
            |-> scan_last)
        else $error("lock key byte not marked last");

endmodule

bind keyboard_scan_code_generator kscg_checker u_kscg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_valid (scan.valid),
    .scan_ready (scan.ready),
    .scan_byte  (scan.scan_byte),
    .scan_last  (scan.last)
);
